/* rtl/core/spab_pkg.sv */
// ----------------------------------------------------------------------------
// spab_pkg
// Shared constants for the sprite pixel blender: depth codes, register
// indexes, channel widths and the reciprocal used for division by 255.
// ----------------------------------------------------------------------------
package spab_pkg;

	localparam int PIX_W  = 8;
	localparam int NCHAN  = 3;
	localparam int PROD_W = 2 * PIX_W;
	localparam int NUM_W  = 3 * PIX_W;

	localparam logic [PIX_W-1:0] MAX_V = 8'd255;

	// ceil(2^32 / 255), exact floor division by 255 for 24-bit values
	localparam int RECIP_SHIFT = 32;
	localparam int RECIP_W     = 25;
	localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;

	localparam logic [1:0] DEPTH_8  = 2'd0;
	localparam logic [1:0] DEPTH_16 = 2'd1;
	localparam logic [1:0] DEPTH_32 = 2'd2;

	localparam logic REG_DEPTH = 1'b0;
	localparam logic REG_KEY   = 1'b1;

endpackage

/* rtl/core/spab_div.sv */
// ----------------------------------------------------------------------------
// spab_div
// Pipelined restoring divider: several dividends over one shared 8-bit
// divisor, BPS quotient bits per stage, with a sideband that rides along.
// ----------------------------------------------------------------------------
module spab_div #(
	parameter int LANES = 6,
	parameter int DW    = 24,
	parameter int BPS   = 4,
	parameter int SW    = 42
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [LANES-1:0][DW-1:0]      in_num,
	input  logic [spab_pkg::PIX_W-1:0]    in_den,
	input  logic [SW-1:0]                 in_side,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [LANES-1:0][DW-1:0]      out_quo,
	output logic [SW-1:0]                 out_side
);
	import spab_pkg::*;

	localparam int NS = DW / BPS;

	logic                              v_q    [NS];
	logic [NS:0]                       en;
	logic [LANES-1:0][DW-1:0]          x_q    [NS];
	logic [LANES-1:0][PIX_W-1:0]       r_q    [NS];
	logic [PIX_W-1:0]                  den_q  [NS];
	logic [SW-1:0]                     side_q [NS];

	always_comb begin
		en[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic                          v_i;
		logic [LANES-1:0][DW-1:0]      x_i;
		logic [LANES-1:0][PIX_W-1:0]   r_i;
		logic [PIX_W-1:0]              den_i;
		logic [SW-1:0]                 side_i;
		logic [LANES-1:0][DW-1:0]      x_n;
		logic [LANES-1:0][PIX_W-1:0]   r_n;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign x_i    = in_num;
			assign r_i    = '0;
			assign den_i  = in_den;
			assign side_i = in_side;
		end else begin : g_next
			assign v_i    = v_q[k-1];
			assign x_i    = x_q[k-1];
			assign r_i    = r_q[k-1];
			assign den_i  = den_q[k-1];
			assign side_i = side_q[k-1];
		end

		always_comb begin
			logic [DW-1:0]    x;
			logic [PIX_W-1:0] r;
			logic [PIX_W:0]   t;
			for (int l = 0; l < LANES; l++) begin
				x = x_i[l];
				r = r_i[l];
				for (int b = 0; b < BPS; b++) begin
					t = {r, x[DW-1]};
					x = {x[DW-2:0], 1'b0};
					if (t >= {1'b0, den_i}) begin
						t    = t - {1'b0, den_i};
						x[0] = 1'b1;
					end
					r = t[PIX_W-1:0];
				end
				x_n[l] = x;
				r_n[l] = r;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en[k]) begin
				v_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				x_q[k]    <= x_n;
				r_q[k]    <= r_n;
				den_q[k]  <= den_i;
				side_q[k] <= side_i;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[NS-1];
	assign out_quo   = x_q[NS-1];
	assign out_side  = side_q[NS-1];

endmodule

/* rtl/core/sprite_pixel_alpha_blend.sv */
// ----------------------------------------------------------------------------
// sprite_pixel_alpha_blend
// Per-pixel sprite blender: color-key copy at 8/16-bit depth, non-premultiplied
// over-compositing at 32-bit ARGB depth; other depth codes leave the write off.
//
// Input stream s_*: s_tdata[31:0] source pixel, s_tdata[63:32] dest pixel.
// Output stream m_*: m_tdata result pixel, m_tuser write enable.
// APB port: 0x0 color depth (reset 2), 0x4 transparent key (reset 0).
// One item enters per clock while s_tready is high. The pipeline depth is
// set by the pipelined divider, which retires DIV_BITS_PER_STAGE quotient
// bits per stage for the six channel divisions by the result alpha.
// Every stage holds a valid bit and loads whenever it is empty or the next
// stage moves, so bubbles collapse and a stalled receiver only backs up the
// pipeline until it is full; s_tready then drops. Reset empties the pipeline
// and restores the register defaults. Write registers only while idle.
// ----------------------------------------------------------------------------
module sprite_pixel_alpha_blend #(
	parameter int DIV_BITS_PER_STAGE = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] source_pixel, [63:32] dest_pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] result_pixel
	output logic        m_tuser,   // [0] write_enable
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import spab_pkg::*;

	localparam int SIDE_W = 2 + 32 + PIX_W;
	localparam int LANES  = 2 * NCHAN;

	logic [1:0]  depth_q;
	logic [15:0] key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_32;
			key_q   <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_DEPTH: depth_q <= pwdata[1:0];
				REG_KEY:   key_q   <= pwdata[15:0];
				default:   ;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_KEY) ? {16'b0, key_q} : {30'b0, depth_q};
	assign pready = 1'b1;

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic en1, en2, en3, en4, en5;
	logic div_in_ready, div_out_valid;

	assign en5      = !v5_s5 || m_tready;
	assign en4      = !v4_s4 || en5;
	assign en3      = !v3_s3 || div_in_ready;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign s_tready = en1;
	assign m_tvalid = v5_s5;

	logic [31:0] src, dst;
	logic        we_d, blend_d;
	logic [31:0] res_d;

	assign src = s_tdata[31:0];
	assign dst = s_tdata[63:32];

	always_comb begin
		we_d    = 1'b0;
		blend_d = 1'b0;
		res_d   = dst;
		case (depth_q)
			DEPTH_8: begin
				if ({8'b0, src[7:0]} != key_q) begin
					we_d  = 1'b1;
					res_d = {24'b0, src[7:0]};
				end
			end
			DEPTH_16: begin
				if (src[15:0] != key_q) begin
					we_d  = 1'b1;
					res_d = {16'b0, src[15:0]};
				end
			end
			DEPTH_32: begin
				if (src[31:24] != '0) begin
					we_d    = 1'b1;
					blend_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// stage 1: decode
	logic [PIX_W-1:0]             sa_s1, da_s1;
	logic [NCHAN-1:0][PIX_W-1:0]  sc_s1, dc_s1;
	logic                         we_s1, blend_s1;
	logic [31:0]                  res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v1_s1 <= 1'b0;
		else if (en1) v1_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sa_s1    <= src[31:24];
			da_s1    <= dst[31:24];
			sc_s1    <= src[23:0];
			dc_s1    <= dst[23:0];
			we_s1    <= we_d;
			blend_s1 <= blend_d;
			res_s1   <= res_d;
		end
	end

	// stage 2: alpha and channel products
	logic [PROD_W-1:0]             pa_s2;
	logic [NCHAN-1:0][PROD_W-1:0]  n1_s2, dd_s2;
	logic [PIX_W-1:0]              nsa_s2;
	logic                          we_s2, blend_s2;
	logic [31:0]                   res_s2;
	logic [PIX_W-1:0]              nsa, nda;

	assign nsa = MAX_V - sa_s1;
	assign nda = MAX_V - da_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v2_s2 <= 1'b0;
		else if (en2) v2_s2 <= v1_s1;
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			pa_s2 <= PROD_W'(nsa) * PROD_W'(nda);
			for (int c = 0; c < NCHAN; c++) begin
				n1_s2[c] <= PROD_W'(sa_s1) * PROD_W'(sc_s1[c]);
				dd_s2[c] <= PROD_W'(da_s1) * PROD_W'(dc_s1[c]);
			end
			nsa_s2   <= nsa;
			we_s2    <= we_s1;
			blend_s2 <= blend_s1;
			res_s2   <= res_s1;
		end
	end

	// stage 3: result alpha and destination numerators
	logic [PIX_W-1:0]              fa_s3;
	logic [NCHAN-1:0][PROD_W-1:0]  n1_s3;
	logic [NCHAN-1:0][NUM_W-1:0]   n2_s3;
	logic                          we_s3, blend_s3;
	logic [31:0]                   res_s3;
	logic [PROD_W:0]               pa_sum;

	assign pa_sum = {1'b0, pa_s2} + {{(PIX_W+1){1'b0}}, pa_s2[PROD_W-1:PIX_W]}
		+ (PROD_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v3_s3 <= 1'b0;
		else if (en3) v3_s3 <= v2_s2;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			fa_s3 <= MAX_V - pa_sum[PROD_W-1:PIX_W];
			for (int c = 0; c < NCHAN; c++) begin
				n2_s3[c] <= NUM_W'(dd_s2[c]) * NUM_W'(nsa_s2);
			end
			n1_s3    <= n1_s2;
			we_s3    <= we_s2;
			blend_s3 <= blend_s2;
			res_s3   <= res_s2;
		end
	end

	// divide all six numerators by the result alpha
	logic [LANES-1:0][NUM_W-1:0] div_num, div_quo;
	logic [SIDE_W-1:0]           div_side_in, div_side_out;

	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			div_num[c]         = NUM_W'(n1_s3[c]);
			div_num[c + NCHAN] = n2_s3[c];
		end
	end

	assign div_side_in = {we_s3, blend_s3, res_s3, fa_s3};

	spab_div #(
		.LANES (LANES),
		.DW    (NUM_W),
		.BPS   (DIV_BITS_PER_STAGE),
		.SW    (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v3_s3),
		.in_ready  (div_in_ready),
		.in_num    (div_num),
		.in_den    (fa_s3),
		.in_side   (div_side_in),
		.out_valid (div_out_valid),
		.out_ready (en4),
		.out_quo   (div_quo),
		.out_side  (div_side_out)
	);

	// stage 4: divide destination terms by 255
	logic [NCHAN-1:0][PIX_W-1:0]  q1_s4, q2f_s4;
	logic [SIDE_W-1:0]            side_s4;
	logic [NCHAN-1:0][NUM_W+RECIP_W-1:0] rp;

	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			rp[c] = (NUM_W+RECIP_W)'(div_quo[c + NCHAN]) * (NUM_W+RECIP_W)'(RECIP_255);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v4_s4 <= 1'b0;
		else if (en4) v4_s4 <= div_out_valid;
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int c = 0; c < NCHAN; c++) begin
				q1_s4[c]  <= div_quo[c][PIX_W-1:0];
				q2f_s4[c] <= rp[c][RECIP_SHIFT +: PIX_W];
			end
			side_s4 <= div_side_out;
		end
	end

	// stage 5: assemble output
	logic                         we4, blend4;
	logic [31:0]                  res4;
	logic [PIX_W-1:0]             fa4;
	logic [NCHAN-1:0][PIX_W-1:0]  chan;

	assign {we4, blend4, res4, fa4} = side_s4;

	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			chan[c] = q1_s4[c] + q2f_s4[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v5_s5 <= 1'b0;
		else if (en5) v5_s5 <= v4_s4;
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			m_tdata <= blend4 ? {fa4, chan} : res4;
			m_tuser <= we4;
		end
	end

endmodule

/* verif/blend_checker.sv */
// ----------------------------------------------------------------------------
// blend_checker
// Watches the pixel input and result streams and the register port, predicts
// each result pixel and write flag, and compares them in order.
// ----------------------------------------------------------------------------
module blend_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] source_pixel, [63:32] dest_pixel
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] result_pixel
	input  logic        m_tuser,   // [0] write_enable
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);
	import spab_pkg::*;

	typedef struct packed {
		logic [31:0] pixel;
		logic        we;
	} blend_out_t;

	blend_out_t  expected_px[$];
	logic [1:0]  depth;
	logic [15:0] key;

	function automatic logic [7:0] mix_chan(int unsigned sa, int unsigned s,
			int unsigned da, int unsigned d, int unsigned fa);
		int unsigned c;
		c = (sa * s) / fa + ((da * d * (255 - sa)) / fa) / 255;
		return c[7:0];
	endfunction

	function automatic blend_out_t blend_pixel(logic [31:0] src, logic [31:0] dst);
		blend_out_t  o;
		int unsigned sa, da, fa;
		o.pixel = dst;
		o.we    = 1'b0;
		if (depth == DEPTH_8) begin
			if ({8'd0, src[7:0]} != key) begin
				o.pixel = {24'd0, src[7:0]};
				o.we    = 1'b1;
			end
		end else if (depth == DEPTH_16) begin
			if (src[15:0] != key) begin
				o.pixel = {16'd0, src[15:0]};
				o.we    = 1'b1;
			end
		end else if (depth == DEPTH_32 && src[31:24] != 8'd0) begin
			sa = {24'd0, src[31:24]};
			da = {24'd0, dst[31:24]};
			fa = 255 - ((255 - sa) * (255 - da)) / 255;
			o.pixel = {fa[7:0],
				mix_chan(sa, {24'd0, src[23:16]}, da, {24'd0, dst[23:16]}, fa),
				mix_chan(sa, {24'd0, src[15:8]}, da, {24'd0, dst[15:8]}, fa),
				mix_chan(sa, {24'd0, src[7:0]}, da, {24'd0, dst[7:0]}, fa)};
			o.we = 1'b1;
		end
		return o;
	endfunction

	assign pending = expected_px.size();

	always @(posedge clk or negedge arst_n) begin
		blend_out_t e;
		if (!arst_n) begin
			depth = DEPTH_32;
			key   = 16'd0;
			fail_count = 0;
			expected_px.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_DEPTH) depth = pwdata[1:0];
				else key = pwdata[15:0];
			end
			if (s_tvalid && s_tready)
				expected_px.insert(expected_px.size(),
					blend_pixel(s_tdata[31:0], s_tdata[63:32]));
			if (m_tvalid && m_tready) begin
				if (expected_px.size() == 0) begin
					$display("%0t: unexpected item: actual %h/%b", $time, m_tdata, m_tuser);
					fail_count++;
				end else begin
					e = expected_px.pop_front();
					if (e.pixel !== m_tdata || e.we !== m_tuser) begin
						$display("%0t: expected %h/%b actual %h/%b", $time,
							e.pixel, e.we, m_tdata, m_tuser);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives pixel pairs and register writes into the sprite blender through all
// depths and a range of key settings, with random stalls on both streams; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	import spab_pkg::*;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
	logic [63:0] s_tdata;
	logic [31:0] m_tdata, pwdata, prdata;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	int          fail_count, pending, cycles;
	bit          no_idle;

	sprite_pixel_alpha_blend u_top (.*);

	blend_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= no_idle || ($urandom_range(99) >= 21);

	task automatic reg_write(logic [2:0] addr, logic [31:0] val);
		paddr  <= addr;
		pwdata <= val;
		psel   <= 1'b1;
		pwrite <= 1'b1;
		@(negedge clk) penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_pixel(logic [31:0] src, logic [31:0] dst);
		while (!no_idle && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {dst, src};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_src(logic [15:0] k);
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(5))
			0: v[15:0] = k;
			1: v[31:24] = 8'd0;
			2: v[31:24] = 8'hff;
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		logic [1:0]  d;
		logic [15:0] k;
		logic [31:0] ext [6];
		ext = '{32'h0, 32'hffffffff, 32'h01000000, 32'hff000000, 32'h00ffffff, 32'h80808080};
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		no_idle = 1'b0; cycles = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (ext[i]) send_pixel(ext[i], ext[5 - i]);
		send_pixel(32'h01ffffff, 32'h00000000);
		send_pixel(32'hfe102030, 32'hff405060);
		drain();
		reg_write({REG_KEY, 2'b00}, 32'h0000_00ab);
		reg_write({REG_DEPTH, 2'b00}, {30'd0, DEPTH_8});
		send_pixel(32'h123456ab, 32'h1);
		send_pixel(32'h000000ac, 32'h2);
		send_pixel(32'hffffffff, 32'h3);
		drain();
		reg_write({REG_KEY, 2'b00}, 32'h0000_01ab);
		send_pixel(32'h000000ab, 32'h4);
		drain();
		reg_write({REG_DEPTH, 2'b00}, {30'd0, DEPTH_16});
		send_pixel(32'h000001ab, 32'h5);
		send_pixel(32'hffff0000, 32'h6);
		drain();
		reg_write({REG_DEPTH, 2'b00}, 32'd3);
		send_pixel(32'hffffffff, 32'h12345678);
		send_pixel(32'h0, 32'hffffffff);
		drain();
		for (int ph = 0; ph < 10; ph++) begin
			d = (ph < 8) ? 2'(ph % 4) : DEPTH_32;
			case (ph % 3)
				0: k = 16'h0000;
				1: k = 16'hffff;
				default: k = 16'($urandom);
			endcase
			if (d == DEPTH_8 && ph > 4) k[15:8] = 8'd0;
			reg_write({REG_KEY, 2'b00}, {16'd0, k});
			reg_write({REG_DEPTH, 2'b00}, {30'd0, d});
			no_idle = (ph == 6);
			repeat (75) send_pixel(rand_src(k), $urandom);
			drain();
		end
		no_idle = 1'b0;
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/spab_pkg.sv
rtl/core/spab_div.sv
rtl/core/sprite_pixel_alpha_blend.sv
verif/blend_checker.sv
verif/tb.sv
